/* src/psc_pkg.sv */
// Shared types and fixed constants of the pressure sensor compensation block.
package psc_pkg;

  // Configuration register map
  typedef enum logic [2:0] {
    REG_SENS_T1  = 3'd0,
    REG_OFF_T1   = 3'd1,
    REG_TCS      = 3'd2,
    REG_TCO      = 3'd3,
    REG_TREF     = 3'd4,
    REG_TEMPSENS = 3'd5,
    REG_MODEL    = 3'd6,
    REG_ZERO     = 3'd7
  } cfg_reg_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 21;

  // Field widths
  localparam int unsigned RAW_W  = 24;
  localparam int unsigned COEF_W = 16;
  localparam int unsigned TEMP_W = 15;
  localparam int unsigned PRES_OUT_W = 21;

  // Datapath widths
  localparam int unsigned DT_W    = 25;  // rawT - C5*2^7
  localparam int unsigned MUL_A_W = 26;
  localparam int unsigned MUL_B_W = 19;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned SUM_W   = 46;  // temp / offset / sensitivity sums
  localparam int unsigned OFF_W   = 37;
  localparam int unsigned SENS_W  = 37;
  localparam int unsigned SENS_LO_W = 18; // low slice of sens for the split multiply
  localparam int unsigned ACC_W   = 62;  // rawP*SENS - OFF*2^21
  localparam int unsigned PRES_W  = MUL_A_W;
  localparam int unsigned PFLR_W  = PROD_W - 16;
  localparam int unsigned PNET_W  = PFLR_W + 1;

  // Shift exponents (Q1+Q3 is 22 for both sensor models)
  localparam int unsigned Q13   = 22;
  localparam int unsigned Q24   = 22;
  localparam int unsigned Q3_A  = 7;
  localparam int unsigned Q3_B  = 6;
  localparam int unsigned Q4    = 5;
  localparam int unsigned Q5    = 7;
  localparam int unsigned Q6    = 21;
  localparam int unsigned QP    = 21;
  localparam int unsigned QPRES = 36;
  localparam int unsigned QSCL  = 16;

  localparam int TEMP_BASE = 2000;
  localparam int PRES_SCALE = 45186;  // 0.01 mbar per count, Q16

  // Output limits
  localparam int TEMP_MIN = -4000;
  localparam int TEMP_MAX = 12500;
  localparam int PRES_MIN = -1048576;
  localparam int PRES_MAX = 1048575;

endpackage

/* src/pressure_sensor_compensation.sv */
// An input transfer starts the state sequence; out_valid_o rises when the result
// is loaded, and the block takes the next item only once that result is loaded,
// so items never overlap and a stalled output holds the block. Six products go
// through one 26x19 signed multiplier in turn. Config writes complete in the cycle they are offered.
// Reset (async, active low): calibration and caches cleared, first conversion
// is temperature, first result is flagged not valid.
module pressure_sensor_compensation #(
  parameter int unsigned TEMP_INTERVAL = 50
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [psc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [psc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // conversion input
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [psc_pkg::RAW_W-1:0]            raw_reading_i,
  // compensated result
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [psc_pkg::TEMP_W-1:0]    temperature_o,
  output logic signed [psc_pkg::PRES_OUT_W-1:0] pressure_o,
  output logic                                 meas_valid_o,
  output logic                                 next_is_temperature_o
);

  localparam int unsigned DIV_W = $clog2(TEMP_INTERVAL + 1);

  localparam int unsigned SUM_W  = psc_pkg::SUM_W;
  localparam int unsigned ACC_W  = psc_pkg::ACC_W;
  localparam int unsigned PROD_W = psc_pkg::PROD_W;

  localparam logic signed [SUM_W-1:0] TempBias = (SUM_W'(1) <<< psc_pkg::Q6) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] OffBias  = (SUM_W'(1) <<< psc_pkg::Q4) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SensBiasA = (SUM_W'(1) <<< psc_pkg::Q3_A) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SensBiasB = (SUM_W'(1) <<< psc_pkg::Q3_B) - SUM_W'(1);
  localparam logic signed [ACC_W-1:0] PresBias = (ACC_W'(1) <<< psc_pkg::QPRES) - ACC_W'(1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DT,
    ST_TEMP_MUL,
    ST_OFF_MUL,
    ST_SENS_MUL,
    ST_SENS,
    ST_PLO_MUL,
    ST_PHI_MUL,
    ST_ACC,
    ST_PRES,
    ST_SCALE_MUL,
    ST_OUT
  } state_e;

  state_e state_q;

  // Calibration registers
  logic [psc_pkg::COEF_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  logic                       model_q;
  logic signed [psc_pkg::PRES_OUT_W-1:0] zero_q;

  // Cached raw conversions and scheduling
  logic [psc_pkg::RAW_W-1:0] raw_t_q, raw_p_q;
  logic [DIV_W-1:0]          div_q;
  logic                      pend_temp_q;
  logic                      startup_q;
  logic                      out_valid_q;

  // Datapath registers
  logic signed [psc_pkg::DT_W-1:0]    dt_q;
  logic signed [PROD_W-1:0]           prod_q;
  logic signed [psc_pkg::TEMP_W-1:0]  temp_q;
  logic signed [psc_pkg::OFF_W-1:0]   off_q;
  logic signed [psc_pkg::SENS_W-1:0]  sens_q;
  logic signed [ACC_W-1:0]            acc_q;
  logic signed [psc_pkg::PRES_W-1:0]  pres_q;

  logic in_xfer, out_load;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign out_load    = (state_q == ST_OUT) & (~out_valid_q | out_ready_i);
  assign out_valid_o = out_valid_q;

  // Configuration writes and raw cache
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q    <= '0;
      c2_q    <= '0;
      c3_q    <= '0;
      c4_q    <= '0;
      c5_q    <= '0;
      c6_q    <= '0;
      model_q <= 1'b0;
      zero_q  <= '0;
      raw_t_q <= '0;
      raw_p_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (psc_pkg::cfg_reg_e'(cfg_index_i))
          psc_pkg::REG_SENS_T1:  c1_q    <= cfg_data_i[psc_pkg::COEF_W-1:0];
          psc_pkg::REG_OFF_T1:   c2_q    <= cfg_data_i[psc_pkg::COEF_W-1:0];
          psc_pkg::REG_TCS:      c3_q    <= cfg_data_i[psc_pkg::COEF_W-1:0];
          psc_pkg::REG_TCO:      c4_q    <= cfg_data_i[psc_pkg::COEF_W-1:0];
          psc_pkg::REG_TREF:     c5_q    <= cfg_data_i[psc_pkg::COEF_W-1:0];
          psc_pkg::REG_TEMPSENS: c6_q    <= cfg_data_i[psc_pkg::COEF_W-1:0];
          psc_pkg::REG_MODEL:    model_q <= cfg_data_i[0];
          psc_pkg::REG_ZERO:     zero_q  <= cfg_data_i;
        endcase
      end
      if (in_xfer) begin
        if (pend_temp_q) begin
          raw_t_q <= raw_reading_i;
        end else begin
          raw_p_q <= raw_reading_i;
        end
      end
    end
  end

  // Shared multiplier operand select
  logic signed [psc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [psc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]           mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_TEMP_MUL: begin
        mul_a = psc_pkg::MUL_A_W'(dt_q);
        mul_b = psc_pkg::MUL_B_W'($signed({1'b0, c6_q}));
      end
      ST_OFF_MUL: begin
        mul_a = psc_pkg::MUL_A_W'(dt_q);
        mul_b = psc_pkg::MUL_B_W'($signed({1'b0, c4_q}));
      end
      ST_SENS_MUL: begin
        mul_a = psc_pkg::MUL_A_W'(dt_q);
        mul_b = psc_pkg::MUL_B_W'($signed({1'b0, c3_q}));
      end
      ST_PLO_MUL: begin
        mul_a = $signed({2'b00, raw_p_q});
        mul_b = $signed({1'b0, sens_q[psc_pkg::SENS_LO_W-1:0]});
      end
      ST_PHI_MUL: begin
        mul_a = $signed({2'b00, raw_p_q});
        mul_b = sens_q[psc_pkg::SENS_W-1:psc_pkg::SENS_LO_W];
      end
      ST_SCALE_MUL: begin
        mul_a = pres_q;
        mul_b = psc_pkg::MUL_B_W'(psc_pkg::PRES_SCALE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Post-multiply arithmetic: divides truncate toward zero, the pressure scaling floors
  logic signed [psc_pkg::DT_W-1:0] dt_d;
  logic signed [SUM_W-1:0] prod_ext;
  logic signed [SUM_W-1:0] t_sum, t_shift;
  logic signed [SUM_W-1:0] o_sum, o_shift;
  logic signed [SUM_W-1:0] s_sum, s_rnd, s_shift;
  logic signed [psc_pkg::TEMP_W-1:0] temp_d;
  logic signed [ACC_W-1:0] acc_init, acc_sum, p_rnd;
  logic signed [psc_pkg::PFLR_W-1:0] p_floor;
  logic signed [psc_pkg::PNET_W-1:0] p_net;
  logic signed [psc_pkg::PRES_OUT_W-1:0] pres_d;

  always_comb begin
    dt_d = $signed({1'b0, raw_t_q}) - $signed({2'b00, c5_q, {psc_pkg::Q5{1'b0}}});
    prod_ext = SUM_W'(prod_q);

    // temperature
    t_sum   = (SUM_W'(psc_pkg::TEMP_BASE) <<< psc_pkg::Q6) + prod_ext;
    t_shift = (t_sum + (t_sum[SUM_W-1] ? TempBias : SUM_W'(0))) >>> psc_pkg::Q6;
    if (t_shift < SUM_W'(psc_pkg::TEMP_MIN)) begin
      temp_d = psc_pkg::TEMP_W'(psc_pkg::TEMP_MIN);
    end else if (t_shift > SUM_W'(psc_pkg::TEMP_MAX)) begin
      temp_d = psc_pkg::TEMP_W'(psc_pkg::TEMP_MAX);
    end else begin
      temp_d = t_shift[psc_pkg::TEMP_W-1:0];
    end

    // offset
    o_sum   = (SUM_W'($signed({1'b0, c2_q})) <<< psc_pkg::Q24) + prod_ext;
    o_shift = (o_sum + (o_sum[SUM_W-1] ? OffBias : SUM_W'(0))) >>> psc_pkg::Q4;

    // sensitivity, shift set by sensor model
    s_sum = (SUM_W'($signed({1'b0, c1_q})) <<< psc_pkg::Q13) + prod_ext;
    s_rnd = s_sum + (s_sum[SUM_W-1] ? (model_q ? SensBiasB : SensBiasA) : SUM_W'(0));
    s_shift = model_q ? (s_rnd >>> psc_pkg::Q3_B) : (s_rnd >>> psc_pkg::Q3_A);

    // rawP*SENS - OFF*2^21, sens split in a low and a high slice
    acc_init = ACC_W'(prod_q) - (ACC_W'(off_q) <<< psc_pkg::QP);
    acc_sum  = acc_q + (ACC_W'(prod_q) <<< psc_pkg::SENS_LO_W);
    p_rnd    = acc_q + (acc_q[ACC_W-1] ? PresBias : ACC_W'(0));

    // floor of scaled pressure, minus zero, saturate
    p_floor = prod_q[PROD_W-1:psc_pkg::QSCL];
    p_net   = psc_pkg::PNET_W'(p_floor) - psc_pkg::PNET_W'(zero_q);
    if (p_net < psc_pkg::PNET_W'(psc_pkg::PRES_MIN)) begin
      pres_d = psc_pkg::PRES_OUT_W'(psc_pkg::PRES_MIN);
    end else if (p_net > psc_pkg::PNET_W'(psc_pkg::PRES_MAX)) begin
      pres_d = psc_pkg::PRES_OUT_W'(psc_pkg::PRES_MAX);
    end else begin
      pres_d = p_net[psc_pkg::PRES_OUT_W-1:0];
    end
  end

  // Datapath registers; the scaled product holds while the result waits
  always_ff @(posedge clk_i) begin
    if (state_q != ST_OUT) begin
      prod_q <= mul_p;
    end
    unique case (state_q)
      ST_DT:       dt_q   <= dt_d;
      ST_OFF_MUL:  temp_q <= temp_d;
      ST_SENS_MUL: off_q  <= o_shift[psc_pkg::OFF_W-1:0];
      ST_SENS:     sens_q <= s_shift[psc_pkg::SENS_W-1:0];
      ST_PHI_MUL:  acc_q  <= acc_init;
      ST_ACC:      acc_q  <= acc_sum;
      ST_PRES:     pres_q <= p_rnd[ACC_W-1:psc_pkg::QPRES];
      default: ;
    endcase
  end

  // Sequencer, scheduling and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q               <= ST_IDLE;
      out_valid_q           <= 1'b0;
      div_q                 <= DIV_W'(TEMP_INTERVAL);
      pend_temp_q           <= 1'b1;
      startup_q             <= 1'b1;
      temperature_o         <= '0;
      pressure_o            <= '0;
      meas_valid_o          <= 1'b0;
      next_is_temperature_o <= 1'b0;
    end else begin
      // output valid: set on a new result, cleared once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE:      if (in_xfer) state_q <= ST_DT;
        ST_DT:        state_q <= ST_TEMP_MUL;
        ST_TEMP_MUL:  state_q <= ST_OFF_MUL;
        ST_OFF_MUL:   state_q <= ST_SENS_MUL;
        ST_SENS_MUL:  state_q <= ST_SENS;
        ST_SENS:      state_q <= ST_PLO_MUL;
        ST_PLO_MUL:   state_q <= ST_PHI_MUL;
        ST_PHI_MUL:   state_q <= ST_ACC;
        ST_ACC:       state_q <= ST_PRES;
        ST_PRES:      state_q <= ST_SCALE_MUL;
        ST_SCALE_MUL: state_q <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            state_q       <= ST_IDLE;
            temperature_o <= temp_q;
            pressure_o    <= pres_d;
            // first result after reset is flagged, sticky valid after
            meas_valid_o  <= ~startup_q;
            startup_q     <= 1'b0;
            // one temperature conversion per TEMP_INTERVAL pressures
            if (div_q == '0) begin
              div_q                 <= DIV_W'(TEMP_INTERVAL);
              pend_temp_q           <= 1'b1;
              next_is_temperature_o <= 1'b1;
            end else begin
              div_q                 <= div_q - DIV_W'(1);
              pend_temp_q           <= 1'b0;
              next_is_temperature_o <= 1'b0;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* tb/sv/pressure_sensor_compensation_tb.sv */
// Self-checking testbench for the pressure sensor compensation block.
`timescale 1ns / 1ps

module pressure_sensor_compensation_tb;

  localparam int TEMP_EVERY  = 50;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 178;

  // One compensated result as the block presents it
  typedef struct packed {
    logic signed [psc_pkg::TEMP_W-1:0]     temperature;
    logic signed [psc_pkg::PRES_OUT_W-1:0] pressure;
    logic                                  meas_valid;
    logic                                  next_is_temperature;
  } reading_t;

  // Tracks calibration and conversion state, predicts each result and checks it
  class compensation_scoreboard;
    longint c_sens, c_off, c_tcs, c_tco, c_tref, c_tempsens, zero_pres;
    bit     model;
    longint t_cache, raw_pres;
    int     divider;
    bit     pending_temp, startup, seen_valid;
    reading_t expected_q[$];
    int     errors, conversions, temp_conversions, checked;

    function new();
      c_sens = 0; c_off = 0; c_tcs = 0; c_tco = 0; c_tref = 0; c_tempsens = 0;
      zero_pres = 0;
      model = 1'b0;
      t_cache = 0;
      raw_pres = 0;
      divider = TEMP_EVERY;
      pending_temp = 1'b1;
      startup = 1'b1;
      seen_valid = 1'b0;
      errors = 0;
      conversions = 0;
      temp_conversions = 0;
      checked = 0;
    endfunction

    function void write_register(psc_pkg::cfg_reg_e idx,
                                 logic [psc_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        psc_pkg::REG_SENS_T1:  c_sens     = longint'(data[psc_pkg::COEF_W-1:0]);
        psc_pkg::REG_OFF_T1:   c_off      = longint'(data[psc_pkg::COEF_W-1:0]);
        psc_pkg::REG_TCS:      c_tcs      = longint'(data[psc_pkg::COEF_W-1:0]);
        psc_pkg::REG_TCO:      c_tco      = longint'(data[psc_pkg::COEF_W-1:0]);
        psc_pkg::REG_TREF:     c_tref     = longint'(data[psc_pkg::COEF_W-1:0]);
        psc_pkg::REG_TEMPSENS: c_tempsens = longint'(data[psc_pkg::COEF_W-1:0]);
        psc_pkg::REG_MODEL:    model      = data[0];
        psc_pkg::REG_ZERO:     zero_pres  = longint'(signed'(data));
        default: ;
      endcase
    endfunction

    // Cache the accepted conversion, run first-order compensation, queue result
    function void note_conversion(logic [psc_pkg::RAW_W-1:0] raw);
      longint dt, t, off, sens, pres, scaled, p;
      int q1, q3;
      reading_t e;
      q1 = model ? 16 : 15;
      q3 = model ? 6 : 7;
      conversions++;
      if (pending_temp) begin
        t_cache = longint'(raw);
        temp_conversions++;
      end else begin
        raw_pres = longint'(raw);
      end

      // Every term is exact; division truncates toward zero
      dt   = t_cache - c_tref * 64'sd128;
      t    = (64'sd2000 * (64'sd1 <<< 21) + dt * c_tempsens) / (64'sd1 <<< 21);
      off  = (c_off * (64'sd1 <<< 22) + c_tco * dt) / 64'sd32;
      sens = (c_sens * (64'sd1 <<< (q1 + q3)) + c_tcs * dt) / (64'sd1 <<< q3);
      pres = (raw_pres * sens - off * (64'sd1 <<< 21)) / (64'sd1 <<< 36);
      // Scale to 0.01 mbar with a floor, then remove the zero
      scaled = pres * 64'sd45186;
      p = (scaled >>> 16) - zero_pres;

      if (t < -4000) t = -4000;
      else if (t > 12500) t = 12500;
      if (p < -1048576) p = -1048576;
      else if (p > 1048575) p = 1048575;

      // First result after reset is flagged not valid
      if (startup) startup = 1'b0;
      else seen_valid = 1'b1;

      // One temperature conversion after every TEMP_EVERY pressures
      if (divider == 0) begin
        divider = TEMP_EVERY;
        pending_temp = 1'b1;
      end else begin
        divider--;
        pending_temp = 1'b0;
      end

      e.temperature = t[psc_pkg::TEMP_W-1:0];
      e.pressure = p[psc_pkg::PRES_OUT_W-1:0];
      e.meas_valid = seen_valid;
      e.next_is_temperature = pending_temp;
      expected_q.push_back(e);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic signed [psc_pkg::TEMP_W-1:0] got_t,
                      logic signed [psc_pkg::PRES_OUT_W-1:0] got_p,
                      logic got_dv, logic got_nt);
      reading_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result temp %0d pres %0d", got_t, got_p));
      end else begin
        e = expected_q.pop_front();
        if (got_t !== e.temperature)
          report($sformatf("result %0d temperature got %0d want %0d",
                           checked, got_t, e.temperature));
        if (got_p !== e.pressure)
          report($sformatf("result %0d pressure got %0d want %0d",
                           checked, got_p, e.pressure));
        if (got_dv !== e.meas_valid)
          report($sformatf("result %0d meas_valid got %b want %b",
                           checked, got_dv, e.meas_valid));
        if (got_nt !== e.next_is_temperature)
          report($sformatf("result %0d next_is_temperature got %b want %b",
                           checked, got_nt, e.next_is_temperature));
        checked++;
      end
    endtask
  endclass

  logic                                  clk_i;
  logic                                  rst_ni;
  logic                                  cfg_valid_i;
  logic                                  cfg_ready_o;
  logic [psc_pkg::CFG_IDX_W-1:0]         cfg_index_i;
  logic [psc_pkg::CFG_DATA_W-1:0]        cfg_data_i;
  logic                                  in_valid_i;
  logic                                  in_ready_o;
  logic [psc_pkg::RAW_W-1:0]             raw_reading_i;
  logic                                  out_valid_o;
  logic                                  out_ready_i;
  logic signed [psc_pkg::TEMP_W-1:0]     temperature_o;
  logic signed [psc_pkg::PRES_OUT_W-1:0] pressure_o;
  logic                                  meas_valid_o;
  logic                                  next_is_temperature_o;

  compensation_scoreboard sb = new();
  bit idling_on;
  int cal_loads;

  psc_pkg::cfg_reg_e reg_order [8] = '{
    psc_pkg::REG_SENS_T1, psc_pkg::REG_OFF_T1, psc_pkg::REG_TCS, psc_pkg::REG_TCO,
    psc_pkg::REG_TREF, psc_pkg::REG_TEMPSENS, psc_pkg::REG_MODEL, psc_pkg::REG_ZERO};
  logic [psc_pkg::RAW_W-1:0] corner_raws [18] = '{
    24'h000000, 24'hFFFFFF, 24'hAAAAAA, 24'h555555, 24'h800000, 24'h7FFFFF,
    24'h000001, 24'hFFFFFE, 24'h5A3C10, 24'h4E2000, 24'h6B1F80, 24'h3C0000,
    24'hF0F0F0, 24'h0F0F0F, 24'hC00000, 24'h400000, 24'h123456, 24'hEDCBA9};

  pressure_sensor_compensation #(
    .TEMP_INTERVAL(TEMP_EVERY)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .raw_reading_i        (raw_reading_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .temperature_o        (temperature_o),
    .pressure_o           (pressure_o),
    .meas_valid_o         (meas_valid_o),
    .next_is_temperature_o(next_is_temperature_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard limit on run time
  initial begin
    #(5_000_000);
    $display("Run timed out waiting for the block");
    $display("Test completed with failures");
    $finish;
  end

  // Receiver side: stall bursts while idling is on
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idling_on && $urandom_range(0, 4) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(temperature_o, pressure_o, meas_valid_o, next_is_temperature_o);
  end

  // Offer one conversion; entered and left at a falling edge
  task automatic send_reading(input logic [psc_pkg::RAW_W-1:0] raw);
    int gap;
    gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    raw_reading_i = raw;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_conversion(raw);
    @(negedge clk_i);
  endtask

  // Block until every queued result has been seen
  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write all eight registers; coefficient writes carry junk in unused bits
  task automatic program_calibration(input int c1, input int c2, input int c3, input int c4,
                                     input int c5, input int c6, input bit mdl,
                                     input int zero);
    logic [psc_pkg::CFG_DATA_W-1:0] w [8];
    w[0] = psc_pkg::CFG_DATA_W'(c1 & 'hFFFF)
           | (psc_pkg::CFG_DATA_W'($urandom_range(0, 31)) << psc_pkg::COEF_W);
    w[1] = psc_pkg::CFG_DATA_W'(c2 & 'hFFFF)
           | (psc_pkg::CFG_DATA_W'($urandom_range(0, 31)) << psc_pkg::COEF_W);
    w[2] = psc_pkg::CFG_DATA_W'(c3 & 'hFFFF)
           | (psc_pkg::CFG_DATA_W'($urandom_range(0, 31)) << psc_pkg::COEF_W);
    w[3] = psc_pkg::CFG_DATA_W'(c4 & 'hFFFF)
           | (psc_pkg::CFG_DATA_W'($urandom_range(0, 31)) << psc_pkg::COEF_W);
    w[4] = psc_pkg::CFG_DATA_W'(c5 & 'hFFFF)
           | (psc_pkg::CFG_DATA_W'($urandom_range(0, 31)) << psc_pkg::COEF_W);
    w[5] = psc_pkg::CFG_DATA_W'(c6 & 'hFFFF)
           | (psc_pkg::CFG_DATA_W'($urandom_range(0, 31)) << psc_pkg::COEF_W);
    w[6] = (psc_pkg::CFG_DATA_W'($urandom) & ~psc_pkg::CFG_DATA_W'(1))
           | psc_pkg::CFG_DATA_W'(mdl);
    w[7] = psc_pkg::CFG_DATA_W'(zero);
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i = 1'b1;
      cfg_index_i = reg_order[i];
      cfg_data_i = w[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_register(reg_order[i], w[i]);
      @(negedge clk_i);
    end
    cfg_valid_i = 1'b0;
    cal_loads++;
  endtask

  // Main sequence
  initial begin
    longint v, span;
    int hold_at;
    logic [psc_pkg::RAW_W-1:0] raw;

    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = psc_pkg::REG_SENS_T1;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    raw_reading_i = '0;
    idling_on = 1'b1;
    cal_loads = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset calibration: first result is flagged not valid, pressure cache still empty
    send_reading(24'h6A3F21);
    send_reading(24'hFFFFFF);
    in_valid_i = 1'b0;
    wait_drained();

    // Field extremes and bit patterns on a typical calibration
    program_calibration(46372, 43981, 29059, 27842, 31553, 28165, 1'b0, 0);
    foreach (corner_raws[i]) send_reading(corner_raws[i]);

    // Random phases, each under its own calibration
    for (int ph = 0; ph < PHASES; ph++) begin
      in_valid_i = 1'b0;
      wait_drained();
      case (ph)
        0: program_calibration(46372, 43981, 29059, 27842, 31553, 28165, 1'b0,
                               int'($urandom_range(0, 4000)) - 2000);
        1: program_calibration(65535, 65535, 65535, 65535, 65535, 65535, 1'b1,
                               psc_pkg::PRES_MAX);
        2: program_calibration(0, 0, 0, 0, 0, 0, 1'b0, psc_pkg::PRES_MIN);
        3: program_calibration(40127, 36924, 23317, 23282, 33464, 28312, 1'b1,
                               -int'($urandom_range(0, 5000)));
        default: program_calibration(
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   1'($urandom_range(0, 1)),
                   $urandom_range(0, 1) ? int'($urandom_range(0, 10000)) - 5000
                                        : int'($urandom_range(0, 2097151)) - 1048576);
      endcase
      hold_at = $urandom_range(20, PHASE_ITEMS - 20);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Idle-free stretches now and then, none at all in the last phase
        if (n % 60 == 0)
          idling_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
        // Sender holds off until the block has emptied
        if (n == hold_at) begin
          in_valid_i = 1'b0;
          wait_drained();
        end

        if (sb.pending_temp && $urandom_range(0, 3) != 0) begin
          // Temperature near the reference point so the result stays in range
          span = longint'(1) << $urandom_range(8, 18);
          v = sb.c_tref * 128 + longint'($urandom_range(0, 2 * span)) - span;
          if (v < 0) v = 0;
          if (v > 64'sd16777215) v = 64'sd16777215;
          raw = v[psc_pkg::RAW_W-1:0];
        end else begin
          case ($urandom_range(0, 9))
            0:       raw = '0;
            1:       raw = '1;
            default: raw = psc_pkg::RAW_W'($urandom);
          endcase
        end
        send_reading(raw);
      end
    end

    // Drain and let the pipeline settle
    in_valid_i = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d conversions (%0d temperature) under %0d calibration loads,",
             sb.conversions, sb.temp_conversions, cal_loads);
    $display("with %0d results compared and %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
src/psc_pkg.sv
src/pressure_sensor_compensation.sv
tb/sv/pressure_sensor_compensation_tb.sv
